// ===== rtl/scsa_pkg.sv =====
// Shared types and constants for the size-class slab allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scsa_pkg;
    localparam int PAGE_BYTES   = 4096;
    localparam int ARENA_PAGES  = 256;
    localparam int HEADER_BYTES = 40;
    localparam int STACK_DEPTH  = 64;
    localparam int NUM_CLASSES  = 9;
    localparam int CW  = 4;
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int AW = 20;
    localparam int PW = 21;
    localparam logic [PW-1:0] PAGE_W = PW'(PAGE_BYTES);
    localparam logic [PW:0] ARENA_END = (PW+1)'(PAGE_BYTES * ARENA_PAGES);
    localparam logic [PW-1:0] HDR_W = PW'(HEADER_BYTES);

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ZERO  = 3'd1;
    localparam logic [2:0] ST_LARGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_STACK = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request and look up class state
        logic commit;  // apply the update and drive the result
    } scsa_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic dummy_ready;
    } scsa_stat_t;
endpackage
`default_nettype wire

// ===== rtl/scsa_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/scsa_ctrl.sv =====
// Controller: sequences each request through lookup and commit.
// Depends on scsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scsa_ctrl import scsa_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire scsa_stat_t stat,
    output logic            busy,
    output scsa_cmd_t       cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;
    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.dummy_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
    assign busy = (state_reg == S_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/scsa_dp.sv =====
// Datapath: per-class registers, free-stack memory and result registers.
// Depends on scsa_pkg and scsa_ram.
`timescale 1ns / 1ps
`default_nettype none
module scsa_dp import scsa_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scsa_cmd_t       cmd_in,
    output scsa_stat_t           stat,
    input  wire logic            cmd,
    input  wire logic [15:0]     req_size,
    input  wire logic [AW-1:0]   free_addr,
    input  wire logic [CW-1:0]   free_class,
    output logic                 done,
    output logic [2:0]           status,
    output logic [AW-1:0]        alloc_addr
);
    logic [PW-1:0]   tail_reg  [NUM_CLASSES];
    logic [PW-1:0]   pend_reg  [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] unused_reg;
    logic [PW-1:0]   fresh_reg;
    logic [CNTW-1:0] cnt_reg   [NUM_CLASSES];

    logic            op_reg;
    logic [AW-1:0]   faddr_reg;
    logic [CW-1:0]   cls_reg;
    logic [2:0]      err_reg;
    logic            done_reg;
    logic [2:0]      status_reg;
    logic [AW-1:0]   addr_reg;

    // Class of a request size: smallest i with 8<<i >= size.
    logic [CW-1:0] req_cls;
    always_comb
    begin
        req_cls = CW'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (17'(req_size) <= (17'd8 << i))
            begin
                req_cls = CW'(i);
            end
        end
    end

    logic [CW-1:0] lk_cls;
    logic          cls_ok;
    logic [SPW-1:0] lk_ptr;
    assign lk_cls = cmd ? free_class : req_cls;
    assign cls_ok = (cls_reg < CW'(NUM_CLASSES));

    // Read address: the top entry of the class stack for a pop.
    always_comb
    begin
        lk_ptr = '0;
        if (lk_cls < CW'(NUM_CLASSES))
        begin
            lk_ptr = SPW'(cnt_reg[lk_cls[CW-1:0]] - CNTW'(1));
        end
    end

    logic [MAW-1:0] raddr, waddr;
    logic [AW-1:0]  rdata;
    logic           we;
    logic [CNTW-1:0] cur_cnt;
    assign raddr = MAW'(lk_cls) * MAW'(STACK_DEPTH) + MAW'(lk_ptr);
    assign cur_cnt = cls_ok ? cnt_reg[cls_reg] : '0;
    assign waddr = MAW'(cls_reg) * MAW'(STACK_DEPTH) + MAW'(cur_cnt[SPW-1:0]);
    assign we = cmd_in.commit && op_reg && cls_ok && (err_reg == ST_OK)
        && (cur_cnt < CNTW'(STACK_DEPTH));

    scsa_ram #(.WIDTH(AW), .DEPTH(MEM_DEPTH)) u_stack (
        .clk(clk), .we(we), .waddr(waddr), .wdata(faddr_reg),
        .raddr(raddr), .rdata(rdata)
    );

    assign stat.dummy_ready = 1'b1;

    // Next-block arithmetic for the carve path.
    logic [PW-1:0] ctail, cpend, blk, cand;
    logic          overflow;
    logic [PW:0]   fresh_end;
    assign ctail = cls_ok ? tail_reg[cls_reg] : '0;
    assign cpend = cls_ok ? pend_reg[cls_reg] : '0;
    assign blk = PW'(8) << cls_reg;
    assign cand = ctail + HDR_W + blk;
    assign overflow = ({1'b0, cand} + {1'b0, HDR_W} + {1'b0, blk}) > {1'b0, cpend};
    assign fresh_end = {1'b0, fresh_reg} + {1'b0, PAGE_W};

    always_ff @(posedge clk)
    begin
        if (cmd_in.load)
        begin
            op_reg <= cmd;
            faddr_reg <= free_addr;
            cls_reg <= lk_cls;
            if (!cmd && req_size == 16'd0)
            begin
                err_reg <= ST_ZERO;
            end
            else if (!cmd && req_size > 16'd2048)
            begin
                err_reg <= ST_LARGE;
            end
            else
            begin
                err_reg <= ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                tail_reg[i] <= PW'(PAGE_BYTES * (i + 1));
                pend_reg[i] <= PW'(PAGE_BYTES * (i + 2));
                cnt_reg[i] <= '0;
            end
            unused_reg <= '1;
            fresh_reg <= PW'(PAGE_BYTES * 10);
            done_reg <= 1'b0;
            status_reg <= ST_OK;
            addr_reg <= '0;
        end
        else
        begin
            done_reg <= cmd_in.commit;
            if (cmd_in.commit)
            begin
                status_reg <= ST_OK;
                addr_reg <= '0;
                if (op_reg)
                begin
                    if (cls_ok)
                    begin
                        if (cur_cnt >= CNTW'(STACK_DEPTH))
                        begin
                            status_reg <= ST_STACK;
                        end
                        else
                        begin
                            cnt_reg[cls_reg] <= cur_cnt + CNTW'(1);
                        end
                    end
                end
                else if (err_reg != ST_OK)
                begin
                    status_reg <= err_reg;
                end
                else if (cur_cnt != '0)
                begin
                    cnt_reg[cls_reg] <= cur_cnt - CNTW'(1);
                    addr_reg <= rdata;
                end
                else if (unused_reg[cls_reg])
                begin
                    unused_reg[cls_reg] <= 1'b0;
                    addr_reg <= AW'(ctail + HDR_W);
                end
                else if (overflow)
                begin
                    if (fresh_end <= ARENA_END)
                    begin
                        tail_reg[cls_reg] <= fresh_reg;
                        pend_reg[cls_reg] <= fresh_end[PW-1:0];
                        fresh_reg <= fresh_end[PW-1:0];
                        addr_reg <= AW'(fresh_reg + HDR_W);
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                else
                begin
                    tail_reg[cls_reg] <= cand;
                    addr_reg <= AW'(cand + HDR_W);
                end
            end
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign alloc_addr = addr_reg;
endmodule
`default_nettype wire

// ===== rtl/size_class_slab_allocator.sv =====
// Top level of the size-class slab allocator: controller plus datapath.
// Depends on scsa_pkg, scsa_ctrl, scsa_dp.
//
// Each request is accepted and its class stack memory read at the accept edge;
// the next edge commits the per-class update. done pulses for one cycle with
// status and alloc_addr after the commit edge; it cannot be stalled.
// A new request is accepted whenever busy is low; busy is high from acceptance until the commit.
`timescale 1ns / 1ps
`default_nettype none
module size_class_slab_allocator import scsa_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic          cmd,
    input  wire logic [15:0]   req_size,
    input  wire logic [AW-1:0] free_addr,
    input  wire logic [CW-1:0] free_class,
    output logic               done,
    output logic [2:0]         status,
    output logic [AW-1:0]      alloc_addr
);
    scsa_cmd_t  ccmd;
    scsa_stat_t stat;

    scsa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .busy(busy), .cmd(ccmd)
    );
    scsa_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd_in(ccmd), .stat(stat),
        .cmd(cmd), .req_size(req_size), .free_addr(free_addr),
        .free_class(free_class), .done(done), .status(status),
        .alloc_addr(alloc_addr)
    );
endmodule
`default_nettype wire

// ===== rtl/scsa_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
// Depends on scsa_pkg and size_class_slab_allocator.
`timescale 1ns / 1ps
`default_nettype none
module scsa_checker import scsa_pkg::*; (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire logic [2:0]    status,
    input wire logic [AW-1:0] alloc_addr
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done) else $error("missing result");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("double result");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> alloc_addr == '0) else $error("addr on error");
endmodule
bind size_class_slab_allocator scsa_checker u_scsa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .alloc_addr(alloc_addr)
);
`default_nettype wire
